### rtl/cst_pkg.sv
`default_nettype none

package cst_pkg;

    // Default build constants
    localparam int MAX_KEYWORD_CHARS_DEF = 10;
    localparam int LINE_BITS_DEF         = 32;
    localparam int KW_COUNT              = 37;
    localparam int KW_W                  = 80;

    // Scanner modes
    typedef enum logic [4:0] {
        M_IDLE, M_WORD, M_DEC, M_ZERO, M_OCT, M_HEX, M_SLASH, M_PLUS, M_MINUS,
        M_STAR, M_EQUAL, M_BANG, M_DOT, M_DOT2, M_LCOMMENT, M_BCOMMENT, M_BSTAR
    } mode_t;

    // Token kinds
    localparam logic [6:0] K_END       = 7'd0;
    localparam logic [6:0] K_ID        = 7'd1;
    localparam logic [6:0] K_INT       = 7'd2;
    localparam logic [6:0] K_BAD       = 7'd3;
    localparam logic [6:0] K_UNCLOSED  = 7'd4;
    localparam logic [6:0] K_LPAREN    = 7'd5;
    localparam logic [6:0] K_RPAREN    = 7'd6;
    localparam logic [6:0] K_LBRACE    = 7'd7;
    localparam logic [6:0] K_RBRACE    = 7'd8;
    localparam logic [6:0] K_LBRACKET  = 7'd9;
    localparam logic [6:0] K_RBRACKET  = 7'd10;
    localparam logic [6:0] K_COMMA     = 7'd11;
    localparam logic [6:0] K_SEMI      = 7'd12;
    localparam logic [6:0] K_COLON     = 7'd13;
    localparam logic [6:0] K_DOT       = 7'd14;
    localparam logic [6:0] K_ELLIPSIS  = 7'd15;
    localparam logic [6:0] K_PLUS      = 7'd16;
    localparam logic [6:0] K_INC       = 7'd17;
    localparam logic [6:0] K_ADD_EQ    = 7'd18;
    localparam logic [6:0] K_MINUS     = 7'd19;
    localparam logic [6:0] K_DEC       = 7'd20;
    localparam logic [6:0] K_SUB_EQ    = 7'd21;
    localparam logic [6:0] K_ARROW     = 7'd22;
    localparam logic [6:0] K_STAR      = 7'd23;
    localparam logic [6:0] K_MUL_EQ    = 7'd24;
    localparam logic [6:0] K_SLASH     = 7'd25;
    localparam logic [6:0] K_DIV_EQ    = 7'd26;
    localparam logic [6:0] K_ASSIGN    = 7'd27;
    localparam logic [6:0] K_EQ        = 7'd28;
    localparam logic [6:0] K_NOT       = 7'd29;
    localparam logic [6:0] K_NE        = 7'd30;
    localparam logic [6:0] K_KEYWORD0  = 7'd31;

    // One result word
    typedef struct packed {
        logic [6:0]  kind;
        logic [63:0] value;
        logic [31:0] line;
        logic [7:0]  len;
    } token_t;

    // Results of one input word, in order
    typedef struct packed {
        logic [1:0]       n;
        token_t [2:0]     tok;
    } result_t;

    // Keyword text, last character in the low byte
    localparam logic [KW_W-1:0] KW_TEXT [KW_COUNT] = '{
        "auto", "break", "case", "char", "const", "continue", "default", "do",
        "double", "extern", "else", "enum", "float", "for", "goto", "int", "if",
        "inline", "long", "return", "restrict", "register", "static", "short",
        "sizeof", "switch", "struct", "signed", "typedef", "unsigned", "union",
        "void", "volatile", "while", "_Bool", "_Complex", "_Imaginary"
    };

    localparam logic [7:0] KW_LEN [KW_COUNT] = '{
        8'd4, 8'd5, 8'd4, 8'd4, 8'd5, 8'd8, 8'd7, 8'd2, 8'd6, 8'd6, 8'd4, 8'd4,
        8'd5, 8'd3, 8'd4, 8'd3, 8'd2, 8'd6, 8'd4, 8'd6, 8'd8, 8'd8, 8'd6, 8'd5,
        8'd6, 8'd6, 8'd6, 8'd6, 8'd7, 8'd8, 8'd5, 8'd4, 8'd8, 8'd5, 8'd5, 8'd8,
        8'd10
    };

    // Kind of a finished word: a keyword code or identifier.
    function automatic logic [6:0] kw_lookup(input logic [KW_W-1:0] key,
                                             input logic [7:0] len);
        logic [6:0] kind;
        kind = K_ID;
        for (int i = 0; i < KW_COUNT; i++) begin
            if (len == KW_LEN[i] && key == KW_TEXT[i]) begin
                kind = K_KEYWORD0 + 7'(i);
            end
        end
        return kind;
    endfunction

endpackage

`default_nettype wire

### rtl/cst_scan.sv
`default_nettype none

module cst_scan import cst_pkg::*; #(
    parameter int MAX_KEYWORD_CHARS = MAX_KEYWORD_CHARS_DEF,
    parameter int LINE_BITS         = LINE_BITS_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        fire,
    input  wire logic [7:0]  source_byte,
    input  wire logic        end_of_input,
    output result_t          res
);

    localparam int KEY_W = MAX_KEYWORD_CHARS * 8;
    localparam logic [LINE_BITS-1:0] LINE_MAX = '1;

    mode_t                mode_reg, mode_next;
    logic [KEY_W-1:0]     key_reg, key_next;
    logic [7:0]           len_reg, len_next;
    logic [63:0]          acc_reg, acc_next;
    logic [LINE_BITS-1:0] line_reg, line_next;
    logic [LINE_BITS-1:0] cline_reg, cline_next;
    logic                 cr_reg, cr_next;

    logic [7:0]  b;
    logic        is_letter, is_digit, is_nl, is_hex;
    logic [3:0]  dval, hval;
    logic [31:0] line32, cline32;
    logic [LINE_BITS-1:0] line_inc;
    token_t      word_tok, flush_tok;
    logic        flush_has, flush_two;

    function automatic token_t mk(input logic [6:0] kind, input logic [63:0] value,
                                  input logic [31:0] line, input logic [7:0] len);
        token_t t;
        t.kind  = kind;
        t.value = value;
        t.line  = line;
        t.len   = len;
        return t;
    endfunction

    // Byte classes
    always_comb begin
        b         = source_byte;
        is_letter = (b >= "a" && b <= "z") || (b >= "A" && b <= "Z") || b == "_";
        is_digit  = b >= "0" && b <= "9";
        is_nl     = b == 8'h0a || b == 8'h0d;
        dval      = 4'(b - "0");
        is_hex    = 1'b1;
        if (is_digit) begin
            hval = dval;
        end else if (b >= "a" && b <= "f") begin
            hval = 4'(b - "a" + 8'd10);
        end else if (b >= "A" && b <= "F") begin
            hval = 4'(b - "A" + 8'd10);
        end else begin
            hval   = 4'd0;
            is_hex = 1'b0;
        end
        line32   = 32'(line_reg);
        cline32  = 32'(cline_reg);
        line_inc = (line_reg == LINE_MAX) ? line_reg : line_reg + 1'b1;
    end

    // Token that the current mode holds if it ends now
    always_comb begin
        word_tok = mk(kw_lookup(key_reg[KW_W-1:0], len_reg), 64'd0, line32, 8'd0);
        if (word_tok.kind == K_ID) begin
            word_tok.len = len_reg;
        end
        flush_has = 1'b1;
        flush_two = 1'b0;
        flush_tok = mk(K_INT, acc_reg, line32, 8'd0);
        unique case (mode_reg)
            M_WORD:                        flush_tok = word_tok;
            M_DEC, M_ZERO, M_OCT, M_HEX:   flush_tok = mk(K_INT, acc_reg, line32, 8'd0);
            M_SLASH:                       flush_tok = mk(K_SLASH, 64'd0, line32, 8'd0);
            M_PLUS:                        flush_tok = mk(K_PLUS, 64'd0, line32, 8'd0);
            M_MINUS:                       flush_tok = mk(K_MINUS, 64'd0, line32, 8'd0);
            M_STAR:                        flush_tok = mk(K_STAR, 64'd0, line32, 8'd0);
            M_EQUAL:                       flush_tok = mk(K_ASSIGN, 64'd0, line32, 8'd0);
            M_BANG:                        flush_tok = mk(K_NOT, 64'd0, line32, 8'd0);
            M_DOT:                         flush_tok = mk(K_DOT, 64'd0, line32, 8'd0);
            M_DOT2: begin
                flush_tok = mk(K_DOT, 64'd0, line32, 8'd0);
                flush_two = 1'b1;
            end
            M_BCOMMENT, M_BSTAR:           flush_tok = mk(K_UNCLOSED, 64'd0, cline32, 8'd0);
            default:                       flush_has = 1'b0;
        endcase
    end

    // Step: end-of-input flush, or mode byte handling, then idle handling when the byte is handed back
    always_comb begin
        logic redo;
        logic [1:0] n;
        res        = '0;
        n          = 2'd0;
        redo       = 1'b0;
        mode_next  = mode_reg;
        key_next   = key_reg;
        len_next   = len_reg;
        acc_next   = acc_reg;
        line_next  = line_reg;
        cline_next = cline_reg;
        cr_next    = cr_reg;
        if (end_of_input) begin
            if (flush_has) begin
                res.tok[n] = flush_tok;
                n = n + 2'd1;
            end
            if (flush_two) begin
                res.tok[n] = flush_tok;
                n = n + 2'd1;
            end
            res.tok[n] = mk(K_END, 64'd0, line32, 8'd0);
            n = n + 2'd1;
            mode_next = M_IDLE;
            cr_next   = 1'b0;
        end else begin
            cr_next = b == 8'h0d;
            unique case (mode_reg)
                M_IDLE: redo = 1'b1;
                M_WORD: begin
                    if (is_letter || is_digit) begin
                        if (len_reg < 8'(MAX_KEYWORD_CHARS)) begin
                            key_next = {key_reg[KEY_W-9:0], b};
                        end
                        if (len_reg != 8'hff) begin
                            len_next = len_reg + 8'd1;
                        end
                    end else begin
                        redo = 1'b1;
                    end
                end
                M_DEC: begin
                    if (is_digit) begin
                        acc_next = {acc_reg[60:0], 3'b0} + {acc_reg[62:0], 1'b0}
                                   + 64'(dval);
                    end else begin
                        redo = 1'b1;
                    end
                end
                M_ZERO: begin
                    if (b == "x" || b == "X") begin
                        mode_next = M_HEX;
                    end else if (is_digit) begin
                        mode_next = M_OCT;
                        acc_next  = 64'(dval);
                    end else begin
                        redo = 1'b1;
                    end
                end
                M_OCT: begin
                    if (is_digit) begin
                        acc_next = {acc_reg[60:0], 3'b0} + 64'(dval);
                    end else begin
                        redo = 1'b1;
                    end
                end
                M_HEX: begin
                    if (is_hex) begin
                        acc_next = {acc_reg[59:0], hval};
                    end else begin
                        redo = 1'b1;
                    end
                end
                M_SLASH: begin
                    if (b == "/") begin
                        mode_next = M_LCOMMENT;
                    end else if (b == "*") begin
                        mode_next  = M_BCOMMENT;
                        cline_next = line_reg;
                    end else if (b == "=") begin
                        res.tok[n] = mk(K_DIV_EQ, 64'd0, line32, 8'd0);
                        n = n + 2'd1;
                        mode_next = M_IDLE;
                    end else begin
                        redo = 1'b1;
                    end
                end
                M_PLUS: begin
                    if (b == "+" || b == "=") begin
                        res.tok[n] = mk((b == "+") ? K_INC : K_ADD_EQ, 64'd0, line32, 8'd0);
                        n = n + 2'd1;
                        mode_next = M_IDLE;
                    end else begin
                        redo = 1'b1;
                    end
                end
                M_MINUS: begin
                    if (b == "-" || b == "=" || b == ">") begin
                        res.tok[n] = mk((b == "-") ? K_DEC : ((b == "=") ? K_SUB_EQ : K_ARROW),
                                        64'd0, line32, 8'd0);
                        n = n + 2'd1;
                        mode_next = M_IDLE;
                    end else begin
                        redo = 1'b1;
                    end
                end
                M_STAR, M_EQUAL, M_BANG: begin
                    if (b == "=") begin
                        res.tok[n] = mk(flush_tok.kind + 7'd1, 64'd0, line32, 8'd0);
                        n = n + 2'd1;
                        mode_next = M_IDLE;
                    end else begin
                        redo = 1'b1;
                    end
                end
                M_DOT: begin
                    if (b == ".") begin
                        mode_next = M_DOT2;
                    end else begin
                        redo = 1'b1;
                    end
                end
                M_DOT2: begin
                    if (b == ".") begin
                        res.tok[n] = mk(K_ELLIPSIS, 64'd0, line32, 8'd0);
                        n = n + 2'd1;
                        mode_next = M_IDLE;
                    end else begin
                        redo = 1'b1;
                    end
                end
                M_LCOMMENT: redo = is_nl;
                M_BCOMMENT, M_BSTAR: begin
                    if (is_nl) begin
                        if (!(b == 8'h0a && cr_reg)) begin
                            line_next = line_inc;
                        end
                        mode_next = M_BCOMMENT;
                    end else if (b == "*") begin
                        mode_next = M_BSTAR;
                    end else if (b == "/" && mode_reg == M_BSTAR) begin
                        mode_next = M_IDLE;
                    end else begin
                        mode_next = M_BCOMMENT;
                    end
                end
                default: redo = 1'b1;
            endcase

            if (redo) begin
                // The pending token of an interrupted mode goes out first.
                if (flush_has) begin
                    res.tok[n] = flush_tok;
                    n = n + 2'd1;
                end
                if (flush_two) begin
                    res.tok[n] = flush_tok;
                    n = n + 2'd1;
                end
                mode_next = M_IDLE;
                case (b)
                    8'h20, 8'h09, 8'h0b, 8'h0c: ;
                    8'h0a, 8'h0d: begin
                        if (!(b == 8'h0a && cr_reg)) begin
                            line_next = line_inc;
                        end
                    end
                    "0": begin
                        mode_next = M_ZERO;
                        acc_next  = 64'd0;
                    end
                    "/": mode_next = M_SLASH;
                    "+": mode_next = M_PLUS;
                    "-": mode_next = M_MINUS;
                    "*": mode_next = M_STAR;
                    "=": mode_next = M_EQUAL;
                    "!": mode_next = M_BANG;
                    ".": mode_next = M_DOT;
                    "(", ")", "{", "}", "[", "]", ",", ";", ":": begin
                        case (b)
                            "(":     res.tok[n] = mk(K_LPAREN, 64'd0, line32, 8'd0);
                            ")":     res.tok[n] = mk(K_RPAREN, 64'd0, line32, 8'd0);
                            "{":     res.tok[n] = mk(K_LBRACE, 64'd0, line32, 8'd0);
                            "}":     res.tok[n] = mk(K_RBRACE, 64'd0, line32, 8'd0);
                            "[":     res.tok[n] = mk(K_LBRACKET, 64'd0, line32, 8'd0);
                            "]":     res.tok[n] = mk(K_RBRACKET, 64'd0, line32, 8'd0);
                            ",":     res.tok[n] = mk(K_COMMA, 64'd0, line32, 8'd0);
                            ";":     res.tok[n] = mk(K_SEMI, 64'd0, line32, 8'd0);
                            default: res.tok[n] = mk(K_COLON, 64'd0, line32, 8'd0);
                        endcase
                        n = n + 2'd1;
                    end
                    default: begin
                        if (is_digit) begin
                            mode_next = M_DEC;
                            acc_next  = 64'(dval);
                        end else if (is_letter) begin
                            mode_next = M_WORD;
                            key_next  = KEY_W'(b);
                            len_next  = 8'd1;
                        end else begin
                            res.tok[n] = mk(K_BAD, 64'(b), line32, 8'd0);
                            n = n + 2'd1;
                        end
                    end
                endcase
            end
        end
        res.n = n;
    end

    // Scanner state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= M_IDLE;
            key_reg   <= '0;
            len_reg   <= 8'd0;
            acc_reg   <= 64'd0;
            line_reg  <= LINE_BITS'(1);
            cline_reg <= LINE_BITS'(1);
            cr_reg    <= 1'b0;
        end else if (fire) begin
            mode_reg  <= mode_next;
            key_reg   <= key_next;
            len_reg   <= len_next;
            acc_reg   <= acc_next;
            line_reg  <= line_next;
            cline_reg <= cline_next;
            cr_reg    <= cr_next;
        end
    end

endmodule

`default_nettype wire

### rtl/cst_outbuf.sv
`default_nettype none

module cst_outbuf import cst_pkg::*; (
    input  wire logic   aclk,
    input  wire logic   aresetn,
    input  wire logic   load,
    input  result_t     res,
    output logic        can_load,
    output logic        m_valid,
    input  wire logic   m_ready,
    output token_t      m_tok,
    output logic        m_last
);

    token_t [2:0] slot_reg;
    logic [1:0]   cnt_reg;
    logic [1:0]   idx_reg;

    // Current word and drain control
    always_comb begin
        m_valid  = cnt_reg != 2'd0;
        m_last   = idx_reg == cnt_reg - 2'd1;
        m_tok    = slot_reg[idx_reg];
        can_load = !m_valid || (m_last && m_ready);
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            slot_reg <= res.tok;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= 2'd0;
            idx_reg <= 2'd0;
        end else if (load) begin
            cnt_reg <= res.n;
            idx_reg <= 2'd0;
        end else if (m_valid && m_ready) begin
            if (m_last) begin
                cnt_reg <= 2'd0;
                idx_reg <= 2'd0;
            end else begin
                idx_reg <= idx_reg + 2'd1;
            end
        end
    end

endmodule

`default_nettype wire

### rtl/c_source_tokenizer_core.sv
// The first token of a byte appears on the result port the cycle after the byte is taken.
// Throughput: one byte per cycle when it yields at most one token and the receiver is
// ready; a byte that yields several tokens (up to 3) holds the input while the result
// buffer drains one word per cycle whenever the receiver is ready.
// Reset (aresetn low, synchronous): scanner idle, line count one, buffer empty.
`default_nettype none

module c_source_tokenizer_core import cst_pkg::*; #(
    parameter int MAX_KEYWORD_CHARS = MAX_KEYWORD_CHARS_DEF,
    parameter int LINE_BITS         = LINE_BITS_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [7:0]  s_source_byte,
    input  wire logic        s_end_of_input,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [6:0]       m_token_kind,
    output logic [63:0]      m_token_value,
    output logic [31:0]      m_line_number,
    output logic [7:0]       m_ident_length,
    output logic             m_last_of_run
);

    logic    in_fire;
    result_t res;
    token_t  tok;

    assign in_fire = s_valid && s_ready;

    // Byte scanner with its state
    cst_scan #(
        .MAX_KEYWORD_CHARS(MAX_KEYWORD_CHARS),
        .LINE_BITS        (LINE_BITS)
    ) u_scan (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .fire        (in_fire),
        .source_byte (s_source_byte),
        .end_of_input(s_end_of_input),
        .res         (res)
    );

    // Result buffer
    cst_outbuf u_outbuf (
        .aclk    (aclk),
        .aresetn (aresetn),
        .load    (in_fire),
        .res     (res),
        .can_load(s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_tok   (tok),
        .m_last  (m_last_of_run)
    );

    assign m_token_kind   = tok.kind;
    assign m_token_value  = tok.value;
    assign m_line_number  = tok.line;
    assign m_ident_length = tok.len;

    // An end mark always produces at least the end token.
    a_end_out: assert property (@(posedge aclk) disable iff (!aresetn)
        in_fire && s_end_of_input |=> m_valid)
        else $error("end mark gave no result");

    // A taken word that is not last keeps the buffer occupied.
    a_more: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && !m_last_of_run |=> m_valid)
        else $error("buffer emptied before last word");

    // Input is never taken while a non-last word waits.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_last_of_run |-> !s_ready)
        else $error("input taken during drain");

endmodule

`default_nettype wire

### sim/tb_token_checker.sv
`timescale 1ns / 1ps

module tb_token_checker import cst_pkg::*; (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    input  wire logic        s_ready,
    input  wire logic [7:0]  s_source_byte,
    input  wire logic        s_end_of_input,
    input  wire logic        m_valid,
    input  wire logic        m_ready,
    input  wire logic [6:0]  m_token_kind,
    input  wire logic [63:0] m_token_value,
    input  wire logic [31:0] m_line_number,
    input  wire logic [7:0]  m_ident_length,
    input  wire logic        m_last_of_run,
    output int               fail_count,
    output int               tokens_pending
);

    localparam int KW_CHARS = 10;

    typedef struct {
        logic [6:0]  kind;
        logic [63:0] value;
        logic [31:0] line;
        logic [7:0]  len;
        logic        last;
    } token_exp_t;

    string kw_names [37] = '{
        "auto", "break", "case", "char", "const", "continue", "default", "do",
        "double", "extern", "else", "enum", "float", "for", "goto", "int", "if",
        "inline", "long", "return", "restrict", "register", "static", "short",
        "sizeof", "switch", "struct", "signed", "typedef", "unsigned", "union",
        "void", "volatile", "while", "_Bool", "_Complex", "_Imaginary"
    };

    // Scanner state as the block should hold it.
    token_exp_t  token_q[$];
    mode_t       scan;
    logic [7:0]  word_chars [KW_CHARS];
    logic [7:0]  word_len;
    logic [63:0] accum;
    logic [31:0] cur_line;
    logic [31:0] open_comment_line;
    logic        prev_cr;
    int          step_tokens;

    assign tokens_pending = token_q.size();

    function automatic void push_token(logic [6:0] kind, logic [63:0] value,
                                       logic [31:0] line, logic [7:0] len);
        token_exp_t t;
        if (step_tokens < 3) begin
            t.kind = kind;
            t.value = value;
            t.line = line;
            t.len = len;
            t.last = 1'b0;
            token_q.push_back(t);
            step_tokens++;
        end
    endfunction

    function automatic void push_simple(logic [6:0] kind);
        push_token(kind, 64'd0, cur_line, 8'd0);
    endfunction

    function automatic bit is_letter(logic [7:0] b);
        return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z") || b == "_";
    endfunction

    function automatic bit is_digit(logic [7:0] b);
        return b >= "0" && b <= "9";
    endfunction

    function automatic void bump_line(logic [7:0] b);
        if (!(b == 8'h0A && prev_cr) && cur_line != 32'hFFFF_FFFF) begin
            cur_line++;
        end
    endfunction

    // A finished word is a keyword only when it fits the buffer and matches exactly.
    function automatic void push_word();
        bit hit;
        if (word_len <= KW_CHARS) begin
            for (int i = 0; i < 37; i++) begin
                if (kw_names[i].len() == word_len) begin
                    hit = 1'b1;
                    for (int j = 0; j < word_len; j++) begin
                        if (kw_names[i][j] != word_chars[j]) hit = 1'b0;
                    end
                    if (hit) begin
                        push_simple(K_KEYWORD0 + 7'(i));
                        return;
                    end
                end
            end
        end
        push_token(K_ID, 64'd0, cur_line, word_len);
    endfunction

    // End of input: emit whatever the current mode still holds.
    function automatic void flush_pending();
        case (scan)
            M_WORD: push_word();
            M_DEC, M_ZERO, M_OCT, M_HEX: push_token(K_INT, accum, cur_line, 8'd0);
            M_SLASH: push_simple(K_SLASH);
            M_PLUS: push_simple(K_PLUS);
            M_MINUS: push_simple(K_MINUS);
            M_STAR: push_simple(K_STAR);
            M_EQUAL: push_simple(K_ASSIGN);
            M_BANG: push_simple(K_NOT);
            M_DOT: push_simple(K_DOT);
            M_DOT2: begin
                push_simple(K_DOT);
                push_simple(K_DOT);
            end
            M_BCOMMENT, M_BSTAR: push_token(K_UNCLOSED, 64'd0, open_comment_line, 8'd0);
            default: ;
        endcase
        scan = M_IDLE;
    endfunction

    // A byte seen between tokens.
    function automatic void idle_byte(logic [7:0] b);
        case (b)
            8'h20, 8'h09, 8'h0B, 8'h0C: return;
            8'h0A, 8'h0D: begin
                bump_line(b);
                return;
            end
            "0": begin
                scan = M_ZERO;
                accum = 64'd0;
                return;
            end
            "/": begin scan = M_SLASH; return; end
            "+": begin scan = M_PLUS; return; end
            "-": begin scan = M_MINUS; return; end
            "*": begin scan = M_STAR; return; end
            "=": begin scan = M_EQUAL; return; end
            "!": begin scan = M_BANG; return; end
            ".": begin scan = M_DOT; return; end
            "(": begin push_simple(K_LPAREN); return; end
            ")": begin push_simple(K_RPAREN); return; end
            "{": begin push_simple(K_LBRACE); return; end
            "}": begin push_simple(K_RBRACE); return; end
            "[": begin push_simple(K_LBRACKET); return; end
            "]": begin push_simple(K_RBRACKET); return; end
            ",": begin push_simple(K_COMMA); return; end
            ";": begin push_simple(K_SEMI); return; end
            ":": begin push_simple(K_COLON); return; end
            default: ;
        endcase
        if (is_digit(b)) begin
            scan = M_DEC;
            accum = 64'(b - "0");
        end else if (is_letter(b)) begin
            scan = M_WORD;
            foreach (word_chars[i]) word_chars[i] = 8'd0;
            word_chars[0] = b;
            word_len = 8'd1;
        end else begin
            push_token(K_BAD, 64'(b), cur_line, 8'd0);
        end
    endfunction

    // Returns 1 when the byte was used up; 0 when it must be seen again from idle.
    function automatic bit mode_byte(logic [7:0] b);
        logic [63:0] digit;
        logic [6:0]  single;
        case (scan)
            M_WORD: begin
                if (!is_letter(b) && !is_digit(b)) begin
                    push_word();
                    return 1'b0;
                end
                if (word_len < KW_CHARS) word_chars[word_len] = b;
                if (word_len != 8'd255) word_len++;
                return 1'b1;
            end
            M_DEC: begin
                if (!is_digit(b)) begin
                    push_token(K_INT, accum, cur_line, 8'd0);
                    return 1'b0;
                end
                accum = accum * 64'd10 + 64'(b - "0");
                return 1'b1;
            end
            M_ZERO: begin
                if (b == "x" || b == "X") begin
                    scan = M_HEX;
                    return 1'b1;
                end
                if (is_digit(b)) begin
                    scan = M_OCT;
                    accum = 64'(b - "0");
                    return 1'b1;
                end
                push_token(K_INT, 64'd0, cur_line, 8'd0);
                return 1'b0;
            end
            M_OCT: begin
                if (!is_digit(b)) begin
                    push_token(K_INT, accum, cur_line, 8'd0);
                    return 1'b0;
                end
                accum = (accum << 3) + 64'(b - "0");
                return 1'b1;
            end
            M_HEX: begin
                if (is_digit(b)) digit = 64'(b - "0");
                else if (b >= "a" && b <= "f") digit = 64'(b - "a" + 10);
                else if (b >= "A" && b <= "F") digit = 64'(b - "A" + 10);
                else begin
                    push_token(K_INT, accum, cur_line, 8'd0);
                    return 1'b0;
                end
                accum = (accum << 4) + digit;
                return 1'b1;
            end
            M_SLASH: begin
                if (b == "/") begin
                    scan = M_LCOMMENT;
                    return 1'b1;
                end
                if (b == "*") begin
                    scan = M_BCOMMENT;
                    open_comment_line = cur_line;
                    return 1'b1;
                end
                if (b == "=") begin
                    push_simple(K_DIV_EQ);
                    scan = M_IDLE;
                    return 1'b1;
                end
                push_simple(K_SLASH);
                return 1'b0;
            end
            M_PLUS: begin
                if (b == "+" || b == "=") begin
                    push_simple(b == "+" ? K_INC : K_ADD_EQ);
                    scan = M_IDLE;
                    return 1'b1;
                end
                push_simple(K_PLUS);
                return 1'b0;
            end
            M_MINUS: begin
                if (b == "-" || b == "=" || b == ">") begin
                    push_simple(b == "-" ? K_DEC : (b == "=" ? K_SUB_EQ : K_ARROW));
                    scan = M_IDLE;
                    return 1'b1;
                end
                push_simple(K_MINUS);
                return 1'b0;
            end
            M_STAR, M_EQUAL, M_BANG: begin
                single = scan == M_STAR ? K_STAR : (scan == M_EQUAL ? K_ASSIGN : K_NOT);
                if (b == "=") begin
                    push_simple(single + 7'd1);
                    scan = M_IDLE;
                    return 1'b1;
                end
                push_simple(single);
                return 1'b0;
            end
            M_DOT: begin
                if (b == ".") begin
                    scan = M_DOT2;
                    return 1'b1;
                end
                push_simple(K_DOT);
                return 1'b0;
            end
            M_DOT2: begin
                if (b == ".") begin
                    push_simple(K_ELLIPSIS);
                    scan = M_IDLE;
                    return 1'b1;
                end
                push_simple(K_DOT);
                push_simple(K_DOT);
                return 1'b0;
            end
            M_LCOMMENT: return !(b == 8'h0A || b == 8'h0D);
            M_BCOMMENT, M_BSTAR: begin
                if (b == 8'h0A || b == 8'h0D) begin
                    bump_line(b);
                    scan = M_BCOMMENT;
                end else if (b == "*") begin
                    scan = M_BSTAR;
                end else if (b == "/" && scan == M_BSTAR) begin
                    scan = M_IDLE;
                end else begin
                    scan = M_BCOMMENT;
                end
                return 1'b1;
            end
            default: return 1'b0;
        endcase
    endfunction

    function automatic void predict_word(logic eoi, logic [7:0] b);
        step_tokens = 0;
        if (eoi) begin
            flush_pending();
            push_simple(K_END);
            prev_cr = 1'b0;
        end else begin
            if (scan == M_IDLE || !mode_byte(b)) begin
                scan = M_IDLE;
                idle_byte(b);
            end
            prev_cr = (b == 8'h0D);
        end
        if (step_tokens > 0) token_q[token_q.size() - 1].last = 1'b1;
    endfunction

    // Sample both channels on the falling edge ahead of the rising edge that takes the word.
    always @(negedge aclk) begin
        token_exp_t e;
        if (!aresetn) begin
            token_q.delete();
            fail_count = 0;
            scan = M_IDLE;
            foreach (word_chars[i]) word_chars[i] = 8'd0;
            word_len = 8'd0;
            accum = 64'd0;
            cur_line = 32'd1;
            open_comment_line = 32'd1;
            prev_cr = 1'b0;
        end else begin
            if (s_valid && s_ready) predict_word(s_end_of_input, s_source_byte);
            if (m_valid && m_ready) begin
                if (token_q.size() == 0) begin
                    $error("token word with nothing expected: kind %0d", m_token_kind);
                    fail_count++;
                end else begin
                    e = token_q.pop_front();
                    if (m_token_kind !== e.kind) begin
                        $error("token_kind expected %0d actual %0d", e.kind, m_token_kind);
                        fail_count++;
                    end
                    if (m_token_value !== e.value) begin
                        $error("token_value expected %0h actual %0h", e.value,
                               m_token_value);
                        fail_count++;
                    end
                    if (m_line_number !== e.line) begin
                        $error("line_number expected %0d actual %0d", e.line,
                               m_line_number);
                        fail_count++;
                    end
                    if (m_ident_length !== e.len) begin
                        $error("ident_length expected %0d actual %0d", e.len,
                               m_ident_length);
                        fail_count++;
                    end
                    if (m_last_of_run !== e.last) begin
                        $error("last_of_run expected %0d actual %0d", e.last,
                               m_last_of_run);
                        fail_count++;
                    end
                end
            end
        end
    end

endmodule

### sim/tb.sv
`timescale 1ns / 1ps

module tb;

    localparam int CYCLE_LIMIT = 600000;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [7:0]  s_source_byte = 8'd0;
    logic        s_end_of_input = 1'b0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [6:0]  m_token_kind;
    logic [63:0] m_token_value;
    logic [31:0] m_line_number;
    logic [7:0]  m_ident_length;
    logic        m_last_of_run;
    int          fail_count;
    int          tokens_pending;
    int          cycle_count = 0;

    // Source stream: bit 8 marks end of input, low bits are the byte.
    logic [8:0]  source_q[$];

    string       kw_pick [8] = '{"int", "while", "_Complex", "volatile", "do", "if",
                                 "_Imaginary", "return"};
    string       op_pick [12] = '{"(", ")", "++", "+=", "->", "--", "-=", "*=", "/=",
                                  "==", "!=", "..."};

    c_source_tokenizer_core dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_source_byte(s_source_byte), .s_end_of_input(s_end_of_input),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_token_kind(m_token_kind), .m_token_value(m_token_value),
        .m_line_number(m_line_number), .m_ident_length(m_ident_length),
        .m_last_of_run(m_last_of_run)
    );

    tb_token_checker u_checker (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_source_byte(s_source_byte), .s_end_of_input(s_end_of_input),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_token_kind(m_token_kind), .m_token_value(m_token_value),
        .m_line_number(m_line_number), .m_ident_length(m_ident_length),
        .m_last_of_run(m_last_of_run),
        .fail_count(fail_count), .tokens_pending(tokens_pending)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // Watchdog on the whole run.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // Receiver: rotates through three stall styles: always ready, ready at random, ready one time in four.
    always @(posedge aclk) begin
        int style;
        style = (cycle_count / 64) % 3;
        case (style)
            0: m_ready <= 1'b1;
            1: m_ready <= $urandom_range(0, 1);
            default: m_ready <= ($urandom_range(0, 3) == 0);
        endcase
    end

    function automatic void add_text(string s);
        for (int i = 0; i < s.len(); i++) source_q.push_back({1'b0, s[i]});
    endfunction

    function automatic void add_byte(logic [7:0] b);
        source_q.push_back({1'b0, b});
    endfunction

    function automatic void add_end();
        source_q.push_back({1'b1, 8'($urandom_range(0, 255))});
    endfunction

    // Well-formed fragment with random content, or noise.
    function automatic void add_fragment();
        int n;
        case ($urandom_range(0, 13))
            0: add_text(kw_pick[$urandom_range(0, 7)]);
            1: begin
                add_byte($urandom_range(0, 1) ? 8'("a" + $urandom_range(0, 25)) : "_");
                n = $urandom_range(0, 12);
                repeat (n) add_byte(8'("0" + $urandom_range(0, 9)) |
                                    ($urandom_range(0, 1) ? 8'h00 : 8'h40));
            end
            2: begin
                add_byte(8'("1" + $urandom_range(0, 8)));
                repeat ($urandom_range(0, 22)) add_byte(8'("0" + $urandom_range(0, 9)));
            end
            3: begin
                add_text($urandom_range(0, 1) ? "0x" : "0X");
                repeat ($urandom_range(0, 18)) begin
                    n = $urandom_range(0, 21);
                    add_byte(n < 10 ? 8'("0" + n) :
                             (n < 16 ? 8'("a" + n - 10) : 8'("A" + n - 16)));
                end
            end
            4: begin
                add_byte("0");
                repeat ($urandom_range(0, 23)) add_byte(8'("0" + $urandom_range(0, 9)));
            end
            5: add_text(op_pick[$urandom_range(0, 11)]);
            6: add_byte(8'($urandom_range(0, 255)));
            7: add_text($urandom_range(0, 1) ? "\n" : ($urandom_range(0, 1) ? "\r" : "\r\n"));
            8: begin
                add_text("/*");
                repeat ($urandom_range(0, 6)) add_byte(8'($urandom_range(0, 255)));
                if ($urandom_range(0, 3) != 0) add_text("*/");
            end
            9: begin
                add_text("//");
                repeat ($urandom_range(0, 5)) add_byte(8'($urandom_range(32, 126)));
                add_text("\n");
            end
            10: if ($urandom_range(0, 2) == 0) add_end();
            11: add_text(".");
            default: add_byte(8'h20);
        endcase
    endfunction

    initial begin
        int burst;
        int gap;
        logic took;
        // Directed text: the compound operators, the number forms and the odd cases.
        add_text("_Imaginary x9_ (){}[],;:+ ++ += -- -= -> *= /= == != ..x 0x1F 089 12ab");
        add_text("\r\n/* a\r\n*/");
        add_byte(8'h00);
        add_byte(8'hFF);
        repeat (12) add_byte("a");
        add_end();
        add_text("/* open");
        add_end();
        add_end();
        // Random part until the stream holds at least 110 words, then a final flush.
        while (source_q.size() < 110) add_fragment();
        add_end();

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        burst = 0;
        while (source_q.size() > 0) begin
            if (burst == 0) begin
                gap = $urandom_range(0, 1) ? 0 : $urandom_range(1, 8);
                if (gap > 0) begin
                    s_valid <= 1'b0;
                    repeat (gap) @(posedge aclk);
                end
                burst = $urandom_range(1, 30);
            end
            s_valid <= 1'b1;
            {s_end_of_input, s_source_byte} <= source_q.pop_front();
            burst--;
            do begin
                @(negedge aclk);
                took = s_valid && s_ready;
                @(posedge aclk);
            end while (!took);
        end
        s_valid <= 1'b0;

        while (tokens_pending != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
        if (fail_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
